### rtl/kpc_pkg.sv
// Shared types, widths, codes and reset values for the key press classifier.
package kpc_pkg;

    localparam int COUNT_WIDTH = 8;
    localparam int CFG_WIDTH   = 8;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam int CODE_WIDTH  = 3;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [CFG_WIDTH-1:0] PRESS_DEBOUNCE_RESET   = CFG_WIDTH'(3);
    localparam logic [CFG_WIDTH-1:0] RELEASE_DEBOUNCE_RESET = CFG_WIDTH'(3);
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET       = CFG_WIDTH'(100);
    localparam logic [CFG_WIDTH-1:0] REPEAT_PRESS_RESET     = CFG_WIDTH'(20);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_PRESS_DEBOUNCE   = 2'd0,
        CFG_RELEASE_DEBOUNCE = 2'd1,
        CFG_LONG_PRESS       = 2'd2,
        CFG_REPEAT_PRESS     = 2'd3
    } cfg_index_t;

    typedef enum logic [CODE_WIDTH-1:0] {
        CODE_RELEASED    = 3'd0,
        CODE_SHORT       = 3'd1,
        CODE_LONG_WAIT   = 3'd2,
        CODE_LONG        = 3'd3,
        CODE_REPEAT_WAIT = 3'd4,
        CODE_REPEAT      = 3'd5
    } key_code_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] press_debounce_count;
        logic [CFG_WIDTH-1:0] release_debounce_count;
        logic [CFG_WIDTH-1:0] long_press_count;
        logic [CFG_WIDTH-1:0] repeat_press_count;
    } kpc_cfg_t;

    typedef struct packed {
        key_code_t previous_key_state;
        key_code_t current_key_state;
    } kpc_result_t;

    // Saturating increment of a run counter.
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH-1:0] r;
        r = (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_WIDTH'(1);
        return r;
    endfunction

    // True when a run count has reached a threshold.
    function automatic logic run_reached(input logic [COUNT_WIDTH-1:0] run,
                                         input logic [CFG_WIDTH-1:0] limit);
        logic r;
        r = CMP_WIDTH'(run) >= CMP_WIDTH'(limit);
        return r;
    endfunction

endpackage

### rtl/kpc_in_if.sv
// Input channel: one sampled key level per word.
interface kpc_in_if;
    logic valid;
    logic ready;
    logic key_down;

    modport source (output valid, output key_down, input ready);
    modport sink (input valid, input key_down, output ready);
endinterface

### rtl/kpc_out_if.sv
// Output channel: previous and current key state codes per word.
interface kpc_out_if import kpc_pkg::*; ();
    logic valid;
    logic ready;
    logic [CODE_WIDTH-1:0] previous_key_state;
    logic [CODE_WIDTH-1:0] current_key_state;

    modport source (output valid, output previous_key_state, output current_key_state,
                    input ready);
    modport sink (input valid, input previous_key_state, input current_key_state,
                  output ready);
endinterface

### rtl/kpc_cfg_regs.sv
// Threshold registers written through the configuration port.
module kpc_cfg_regs
    import kpc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    output kpc_cfg_t                   cfg
);

    kpc_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_debounce_count   <= PRESS_DEBOUNCE_RESET;
            cfg_reg.release_debounce_count <= RELEASE_DEBOUNCE_RESET;
            cfg_reg.long_press_count       <= LONG_PRESS_RESET;
            cfg_reg.repeat_press_count     <= REPEAT_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PRESS_DEBOUNCE:   cfg_reg.press_debounce_count   <= cfg_data;
                CFG_RELEASE_DEBOUNCE: cfg_reg.release_debounce_count <= cfg_data;
                CFG_LONG_PRESS:       cfg_reg.long_press_count       <= cfg_data;
                CFG_REPEAT_PRESS:     cfg_reg.repeat_press_count     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/kpc_core.sv
// Sample register, key state machine and run counters; one update per sample.
module kpc_core
    import kpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  kpc_cfg_t    cfg,
    input  logic        in_fire,
    input  logic        in_key_down,
    output logic        res_valid,
    output kpc_result_t res
);

    typedef enum logic [2:0] {
        ST_WAIT    = 3'd0,
        ST_SHORT   = 3'd1,
        ST_LONG    = 3'd2,
        ST_REPEAT  = 3'd3,
        ST_RELEASE = 3'd4
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_WIDTH-1:0] rel_run_reg, rel_run_next;
    logic [COUNT_WIDTH-1:0] prs_run_reg, prs_run_next;
    key_code_t              prior_reg, prior_next;
    key_code_t              present_reg, present_next;
    logic                   smp_valid_reg;
    logic                   smp_key_reg;

    // per-state parameters of the shared held-key handling
    logic                   held;
    logic [CFG_WIDTH-1:0]   hold_limit;
    key_code_t              rel_prior;
    state_t                 hold_state;
    key_code_t              hold_prior;
    key_code_t              hold_cur;
    logic [COUNT_WIDTH-1:0] rel_inc;
    logic [COUNT_WIDTH-1:0] prs_inc;

    always_comb
    begin
        state_next   = state_reg;
        rel_run_next = rel_run_reg;
        prs_run_next = prs_run_reg;
        prior_next   = prior_reg;
        present_next = present_reg;
        held         = 1'b0;
        hold_limit   = cfg.long_press_count;
        rel_prior    = CODE_SHORT;
        hold_state   = ST_LONG;
        hold_prior   = CODE_LONG_WAIT;
        hold_cur     = CODE_LONG;
        rel_inc      = sat_inc(rel_run_reg);
        prs_inc      = sat_inc(prs_run_reg);

        if (smp_valid_reg)
        begin
            unique case (state_reg)
                ST_SHORT:
                begin
                    held         = 1'b1;
                    prior_next   = CODE_SHORT;
                    present_next = CODE_LONG_WAIT;
                end
                ST_LONG:
                begin
                    held         = 1'b1;
                    prior_next   = CODE_LONG;
                    present_next = CODE_REPEAT_WAIT;
                    hold_limit   = cfg.repeat_press_count;
                    rel_prior    = CODE_LONG;
                    hold_state   = ST_REPEAT;
                    hold_prior   = CODE_REPEAT_WAIT;
                    hold_cur     = CODE_REPEAT;
                end
                ST_REPEAT:
                begin
                    held         = 1'b1;
                    prior_next   = CODE_REPEAT;
                    present_next = CODE_REPEAT_WAIT;
                    hold_limit   = cfg.repeat_press_count;
                    rel_prior    = CODE_REPEAT_WAIT;
                    hold_state   = ST_REPEAT;
                    hold_prior   = CODE_REPEAT_WAIT;
                    hold_cur     = CODE_REPEAT;
                end
                ST_RELEASE:
                begin
                    rel_run_next = '0;
                    prs_run_next = '0;
                    state_next   = ST_WAIT;
                    prior_next   = CODE_RELEASED;
                    present_next = CODE_RELEASED;
                end
                default:
                begin
                    state_next   = ST_WAIT;
                    rel_run_next = '0;
                    if (smp_key_reg)
                    begin
                        prs_run_next = prs_inc;
                        if (run_reached(prs_inc, cfg.press_debounce_count))
                        begin
                            prs_run_next = '0;
                            state_next   = ST_SHORT;
                            prior_next   = CODE_RELEASED;
                            present_next = CODE_SHORT;
                        end
                    end
                    else
                    begin
                        prs_run_next = '0;
                    end
                end
            endcase

            if (held)
            begin
                if (!smp_key_reg)
                begin
                    rel_run_next = rel_inc;
                    prs_run_next = '0;
                    if (run_reached(rel_inc, cfg.release_debounce_count))
                    begin
                        rel_run_next = '0;
                        state_next   = ST_RELEASE;
                        prior_next   = rel_prior;
                        present_next = CODE_RELEASED;
                    end
                end
                else
                begin
                    prs_run_next = prs_inc;
                    rel_run_next = '0;
                    if (run_reached(prs_inc, hold_limit))
                    begin
                        prs_run_next = '0;
                        state_next   = hold_state;
                        prior_next   = hold_prior;
                        present_next = hold_cur;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT;
            rel_run_reg   <= '0;
            prs_run_reg   <= '0;
            prior_reg     <= CODE_RELEASED;
            present_reg   <= CODE_RELEASED;
            smp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rel_run_reg   <= rel_run_next;
            prs_run_reg   <= prs_run_next;
            prior_reg     <= prior_next;
            present_reg   <= present_next;
            smp_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            smp_key_reg <= in_key_down;
        end
    end

    assign res_valid              = smp_valid_reg;
    assign res.previous_key_state = prior_next;
    assign res.current_key_state  = present_next;

endmodule

### rtl/kpc_out_buf.sv
// Two-entry result buffer; reports room counting the sample still in flight.
module kpc_out_buf
    import kpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  kpc_result_t push_data,
    output logic        room,
    kpc_out_if.source   state_out
);

    kpc_result_t mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        pop;
    logic [2:0]  reserved;

    assign pop = state_out.valid && state_out.ready;

    // slots held after this edge: stored words plus the one being computed, less the one popped
    assign reserved = {1'b0, count_reg} + {2'b0, push} - {2'b0, pop};
    assign room     = reserved < 3'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= reserved[1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign state_out.valid              = count_reg != 2'd0;
    assign state_out.previous_key_state = mem[rd_ptr_reg].previous_key_state;
    assign state_out.current_key_state  = mem[rd_ptr_reg].current_key_state;

endmodule

### rtl/key_press_classifier.sv
// Top level of the key press classifier.
// One key sample per input word, one pair of state codes (previous, current) per output
// word. A word can be taken every cycle while the buffer has room; each word sits in the
// sample register, where the state machine and run counters update, and its result is
// readable from the two-entry output buffer on the following cycle. While the consumer
// stalls, the buffer absorbs up to two results before input ready drops. The user writes
// thresholds through cfg_we/cfg_index/cfg_data only while the block is idle (not enforced).
module key_press_classifier
    import kpc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    kpc_in_if.sink                     key_in,
    kpc_out_if.source                  state_out
);

    kpc_cfg_t    cfg;
    logic        in_fire;
    logic        res_valid;
    kpc_result_t res;
    logic        room;

    assign key_in.ready = room;
    assign in_fire      = key_in.valid && room;

    kpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kpc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_fire     (in_fire),
        .in_key_down (key_in.key_down),
        .res_valid   (res_valid),
        .res         (res)
    );

    kpc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .room      (room),
        .state_out (state_out)
    );

endmodule

### tb/tb_top.sv
// Self-checking bench for key_press_classifier: random key traces against a built-in state predictor.
module tb_top;
    import kpc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {
        KS_WAIT,
        KS_SHORT,
        KS_LONG,
        KS_REPEAT,
        KS_RELEASE
    } press_phase_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_index_t cfg_index;
    logic [CFG_WIDTH-1:0] cfg_data;

    kpc_in_if key_if ();
    kpc_out_if res_if ();

    key_press_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_in    (key_if),
        .state_out (res_if)
    );

    // Predictor state and threshold shadow
    press_phase_t kp_phase = KS_WAIT;
    logic [COUNT_WIDTH-1:0] released_len = '0;
    logic [COUNT_WIDTH-1:0] pressed_len = '0;
    key_code_t code_prev = CODE_RELEASED;
    key_code_t code_cur = CODE_RELEASED;
    logic [CFG_WIDTH-1:0] thr_press = PRESS_DEBOUNCE_RESET;
    logic [CFG_WIDTH-1:0] thr_release = RELEASE_DEBOUNCE_RESET;
    logic [CFG_WIDTH-1:0] thr_long = LONG_PRESS_RESET;
    logic [CFG_WIDTH-1:0] thr_repeat = REPEAT_PRESS_RESET;

    logic key_samples[$];
    kpc_result_t expected_codes[$];
    kpc_result_t due_codes;

    int words_sent;
    int words_seen;
    int mismatches = 0;
    int cycles = 0;
    int hold_left;
    logic hold_done;
    logic quiet_in;
    logic quiet_out;

    assign quiet_in = (words_sent >= 400) && (words_sent < 700);
    assign quiet_out = (words_seen >= 400) && (words_seen < 700);

    function automatic logic [COUNT_WIDTH-1:0] run_next(input logic [COUNT_WIDTH-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    // Shared by all held phases: count toward a release or toward the next hold report.
    function automatic void track_hold(input logic down, input logic [CFG_WIDTH-1:0] limit,
                                       input key_code_t rel_prev, input press_phase_t nxt,
                                       input key_code_t hold_prev, input key_code_t hold_cur);
        if (!down)
        begin
            released_len = run_next(released_len);
            pressed_len = '0;
            if (released_len >= thr_release)
            begin
                released_len = '0;
                kp_phase = KS_RELEASE;
                code_prev = rel_prev;
                code_cur = CODE_RELEASED;
            end
        end
        else
        begin
            pressed_len = run_next(pressed_len);
            released_len = '0;
            if (pressed_len >= limit)
            begin
                pressed_len = '0;
                kp_phase = nxt;
                code_prev = hold_prev;
                code_cur = hold_cur;
            end
        end
    endfunction

    function automatic kpc_result_t classify_sample(input logic down);
        kpc_result_t r;
        case (kp_phase)
            KS_SHORT:
            begin
                code_prev = CODE_SHORT;
                code_cur = CODE_LONG_WAIT;
                track_hold(down, thr_long, CODE_SHORT, KS_LONG, CODE_LONG_WAIT, CODE_LONG);
            end
            KS_LONG:
            begin
                code_prev = CODE_LONG;
                code_cur = CODE_REPEAT_WAIT;
                track_hold(down, thr_repeat, CODE_LONG, KS_REPEAT, CODE_REPEAT_WAIT,
                           CODE_REPEAT);
            end
            KS_REPEAT:
            begin
                code_prev = CODE_REPEAT;
                code_cur = CODE_REPEAT_WAIT;
                track_hold(down, thr_repeat, CODE_REPEAT_WAIT, KS_REPEAT, CODE_REPEAT_WAIT,
                           CODE_REPEAT);
            end
            KS_RELEASE:
            begin
                // the release phase covers a single sample, which is ignored
                released_len = '0;
                pressed_len = '0;
                kp_phase = KS_WAIT;
                code_prev = CODE_RELEASED;
                code_cur = CODE_RELEASED;
            end
            default:
            begin
                kp_phase = KS_WAIT;
                if (down)
                begin
                    pressed_len = run_next(pressed_len);
                    released_len = '0;
                    if (pressed_len >= thr_press)
                    begin
                        pressed_len = '0;
                        kp_phase = KS_SHORT;
                        code_prev = CODE_RELEASED;
                        code_cur = CODE_SHORT;
                    end
                end
                else
                begin
                    pressed_len = '0;
                    released_len = '0;
                end
            end
        endcase
        r.previous_key_state = code_prev;
        r.current_key_state = code_cur;
        return r;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_WIDTH-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            CFG_PRESS_DEBOUNCE:   thr_press = v;
            CFG_RELEASE_DEBOUNCE: thr_release = v;
            CFG_LONG_PRESS:       thr_long = v;
            default:              thr_repeat = v;
        endcase
    endtask

    task automatic load_thresholds(input logic [CFG_WIDTH-1:0] p, input logic [CFG_WIDTH-1:0] r,
                                   input logic [CFG_WIDTH-1:0] l, input logic [CFG_WIDTH-1:0] t);
        write_reg(CFG_PRESS_DEBOUNCE, p);
        write_reg(CFG_RELEASE_DEBOUNCE, r);
        write_reg(CFG_LONG_PRESS, l);
        write_reg(CFG_REPEAT_PRESS, t);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Checked at negedge so driver and monitor updates of this edge have settled.
    task automatic wait_drained();
        while (key_samples.size() != 0 || key_if.valid || expected_codes.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_bits(input logic [31:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--)
            key_samples.push_back(bits[i]);
    endtask

    // Mostly clean press/hold/release strokes, some random chatter in between.
    task automatic add_keystrokes(input int n, input int hold_lo, input int hold_hi,
                                  input int gap_lo, input int gap_hi, input int glitch_pct);
        int added;
        int h;
        int g;
        int slip;
        int rslip;
        added = 0;
        while (added < n)
        begin
            if ($urandom_range(99) < 15)
            begin
                h = $urandom_range(4, 1);
                repeat (h) key_samples.push_back(1'($urandom_range(1)));
                added += h;
            end
            else
            begin
                h = $urandom_range(hold_hi, hold_lo);
                g = $urandom_range(gap_hi, gap_lo);
                slip = ($urandom_range(99) < glitch_pct) ? $urandom_range(h) : -1;
                rslip = ($urandom_range(99) < glitch_pct) ? $urandom_range(g) : -1;
                for (int i = 0; i < h; i++)
                    key_samples.push_back(i != slip);
                for (int i = 0; i < g; i++)
                    key_samples.push_back(i == rslip);
                added += h + g;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PRESS_DEBOUNCE;
        cfg_data = '0;
        key_if.valid = 1'b0;
        key_if.key_down = 1'b0;
        res_if.ready = 1'b0;
        forever #5 clk = ~clk;
    end

    // Input driver: a word stays on the bus until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_if.valid <= 1'b0;
            key_if.key_down <= 1'b0;
            words_sent <= 0;
        end
        else
        begin
            if (key_if.valid && key_if.ready)
            begin
                expected_codes.push_back(classify_sample(key_if.key_down));
                words_sent <= words_sent + 1;
            end
            if (!key_if.valid || key_if.ready)
            begin
                if (key_samples.size() != 0 && (quiet_in || $urandom_range(99) >= 20))
                begin
                    key_if.valid <= 1'b1;
                    key_if.key_down <= key_samples.pop_front();
                end
                else
                begin
                    key_if.valid <= 1'b0;
                    key_if.key_down <= 1'($urandom_range(1));
                end
            end
        end
    end

    // One long consumer stall, early in the extreme-threshold phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && words_seen >= 250)
        begin
            hold_left <= 80;
            hold_done <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            words_seen <= 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                words_seen <= words_seen + 1;
                if (expected_codes.size() == 0)
                begin
                    $error("result word with nothing expected: prev %0d cur %0d",
                           res_if.previous_key_state, res_if.current_key_state);
                    mismatches++;
                end
                else
                begin
                    due_codes = expected_codes.pop_front();
                    if (res_if.previous_key_state !== due_codes.previous_key_state)
                    begin
                        $error("previous_key_state: expected %0d, got %0d",
                               due_codes.previous_key_state, res_if.previous_key_state);
                        mismatches++;
                    end
                    if (res_if.current_key_state !== due_codes.current_key_state)
                    begin
                        $error("current_key_state: expected %0d, got %0d",
                               due_codes.current_key_state, res_if.current_key_state);
                        mismatches++;
                    end
                end
            end
            res_if.ready <= (hold_left == 0) && (quiet_out || $urandom_range(99) >= 20);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset thresholds: bounce on press, confirm, bounce on release, then long holds
        push_bits(32'b1101110010000, 13);
        add_keystrokes(100, 100, 160, 3, 8, 0);
        wait_drained();

        // every state and every release path with the lowest thresholds
        load_thresholds(8'd1, 8'd1, 8'd1, 8'd1);
        push_bits(32'b011110010111000, 15);
        wait_drained();

        // zero thresholds: met by the first matching sample
        load_thresholds(8'd0, 8'd0, 8'd0, 8'd0);
        add_keystrokes(40, 0, 4, 0, 4, 20);
        wait_drained();

        // press debounce at the top of the counter range
        load_thresholds(8'd255, 8'd1, 8'd1, 8'd3);
        add_keystrokes(250, 256, 260, 1, 3, 0);
        wait_drained();

        load_thresholds(8'd2, 8'd3, 8'd6, 8'd4);
        add_keystrokes(100, 1, 30, 1, 8, 10);
        wait_drained();

        load_thresholds(8'd5, 8'd1, 8'd3, 8'd1);
        add_keystrokes(80, 1, 20, 1, 8, 10);
        wait_drained();

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
